// ===== hw/rtl/tdfs_pkg.sv =====
// tdfs_pkg: shared types and constants for the timer divider factor search
// used by tdfs_front, tdfs_div, tdfs_back and timer_divider_factor_search
// no dependencies
package tdfs_pkg;

  // largest 16-bit timer factor
  localparam logic [15:0] FACTOR_MAX = 16'hFFFF;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // one input item
  typedef struct packed {
    logic [31:0] core_clock_hz;
    logic [30:0] bus_clock_hz;
    logic [31:0] sample_rate_hz;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        status;
    logic [15:0] prescale_value;
    logic [15:0] reload_value;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        rate_zero;
    logic [31:0] tclk;
    logic [31:0] rate;
  } task_t;

  // request to the shared serial divider
  typedef struct packed {
    logic        start;
    logic [5:0]  steps;
    logic [31:0] rem_init;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // answer from the shared serial divider
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/timer_divider_factor_search.sv =====
// timer_divider_factor_search: top level, front classifier and back search
// sequencer joined by a two-entry item queue
// depends on tdfs_pkg, tdfs_front, tdfs_back
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+------------------------------
//   input    | push, full, in_item         | taken when push && !full
//   result   | empty, pop, out_item        | taken when pop && !empty
//
// an item with zero rate is answered without a divide; any other item takes the
// 32-step serial divide of timer clock by rate, and a divider up to 65535 is then answered directly
// a split divider adds one 16-step divide plus set-up and compare per trial ratio,
// up to 65534 trials
// reset is synchronous and active low; both queues start empty
// the front keeps taking items while the back searches, until its queue is full;
// the back takes a new item only when the result queue has space
module timer_divider_factor_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  tdfs_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output tdfs_pkg::out_item_t out_item
);

  logic            task_valid;
  logic            task_pop;
  tdfs_pkg::task_t task_head;

  // item intake and classification
  tdfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .task_valid (task_valid),
    .task_head  (task_head),
    .task_pop   (task_pop)
  );

  // divide, factor search and result queue
  tdfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .task_valid (task_valid),
    .task_head  (task_head),
    .task_pop   (task_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule

// ===== hw/rtl/tdfs_front.sv =====
// tdfs_front: accepts input items, derives the timer clock, flags a zero rate
// and holds them in a two-entry queue for the back end
// depends on tdfs_pkg
module tdfs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tdfs_pkg::in_item_t in_item,
  output logic               task_valid,
  output tdfs_pkg::task_t    task_head,
  input  logic               task_pop
);

  tdfs_pkg::task_t q_mem [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            accept;
  logic [31:0]     bus_ext;
  tdfs_pkg::task_t new_task;

  // classify the incoming item
  always_comb begin
    bus_ext            = {1'b0, in_item.bus_clock_hz};
    new_task.rate_zero = (in_item.sample_rate_hz == 32'd0);
    new_task.tclk      = (in_item.core_clock_hz == bus_ext) ? bus_ext
                                                            : {in_item.bus_clock_hz, 1'b0};
    new_task.rate      = in_item.sample_rate_hz;
  end

  // queue control
  assign full       = (cnt_r == 2'd2);
  assign accept     = push && !full;
  assign task_valid = (cnt_r != 2'd0);
  assign task_head  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = task_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, accept} - {1'b0, task_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr_r] <= new_task;
    end
  end

  // back end takes only what is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    task_pop |-> task_valid)
    else $error("front: item taken from empty queue");

endmodule

// ===== hw/rtl/tdfs_div.sv =====
// tdfs_div: restoring divider, one quotient bit per cycle, with a preloadable
// partial remainder so that short divisions take fewer steps
// depends on tdfs_pkg
module tdfs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tdfs_pkg::div_req_t  req,
  output tdfs_pkg::div_rsp_t  rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] trial;
  logic        take;

  // one restoring step
  always_comb begin
    trial    = {rem_r, dvd_r[31]} - {1'b0, dsr_r};
    take     = !trial[32];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      dvd_nxt  = req.dividend;
      quot_nxt = 32'd0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = take ? trial[31:0] : {rem_r[30:0], dvd_r[31]};
      dvd_nxt  = {dvd_r[30:0], 1'b0};
      quot_nxt = {quot_r[30:0], take};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/tdfs_back.sv =====
// tdfs_back: sequencer that divides the timer clock by the rate, searches the
// factor pair and queues results in a two-entry output queue
// depends on tdfs_pkg and tdfs_div
module tdfs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                task_valid,
  input  tdfs_pkg::task_t     task_head,
  output logic                task_pop,
  output logic                empty,
  input  logic                pop,
  output tdfs_pkg::out_item_t out_item
);

  localparam logic [5:0] STEPS_FULL = 6'd32;
  localparam logic [5:0] STEPS_HALF = 6'd16;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_CLASS  = 7'b0000100,
    S_TRIAL  = 7'b0001000,
    S_TWAIT  = 7'b0010000,
    S_EVAL   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [31:0]          div_r, div_nxt;
  logic [15:0]          r_r, r_nxt;
  logic [15:0]          q_r, q_nxt;
  logic [31:0]          err_r, err_nxt;
  logic [15:0]          best_r, best_r_nxt;
  logic [15:0]          best_q_r, best_q_nxt;
  logic [31:0]          best_err_r, best_err_nxt;
  logic                 have_r, have_nxt;
  tdfs_pkg::div_req_t   div_req;
  tdfs_pkg::div_rsp_t   div_rsp;
  logic                 res_push;
  tdfs_pkg::out_item_t  res_data;
  logic                 res_space;
  logic [16:0]          r0_low;
  logic [17:0]          r0;
  logic [15:0]          r0_clamp;
  logic                 sat;

  tdfs_pkg::out_item_t  res_mem [2];
  logic                 res_wr_r, res_wr_nxt;
  logic                 res_rd_r, res_rd_nxt;
  logic [1:0]           res_cnt_r, res_cnt_nxt;
  logic                 res_pop;

  tdfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // first trial ratio: divider / 65535 + 1, clamped to the factor range;
  // the quotient short-cut is exact below the top input value, which clamps anyway
  always_comb begin
    r0_low   = {1'b0, div_r[31:16]} + {1'b0, div_r[15:0]} + 17'd1;
    r0       = {2'b0, div_r[31:16]} + {17'd0, r0_low[16]} + 18'd1;
    r0_clamp = (r0[17:16] != 2'b00) ? tdfs_pkg::FACTOR_MAX : r0[15:0];
    // quotient above 16 bits saturates
    sat      = (div_r[31:16] >= r_r);
  end

  assign res_space = (res_cnt_r != 2'd2);

  // search sequencer
  always_comb begin
    state_nxt    = state_r;
    div_nxt      = div_r;
    r_nxt        = r_r;
    q_nxt        = q_r;
    err_nxt      = err_r;
    best_r_nxt   = best_r;
    best_q_nxt   = best_q_r;
    best_err_nxt = best_err_r;
    have_nxt     = have_r;
    task_pop     = 1'b0;
    res_push     = 1'b0;
    res_data.status         = tdfs_pkg::STATUS_ERR;
    res_data.prescale_value = 16'd0;
    res_data.reload_value   = 16'd0;
    div_req.start    = 1'b0;
    div_req.steps    = STEPS_FULL;
    div_req.rem_init = 32'd0;
    div_req.dividend = task_head.tclk;
    div_req.divisor  = task_head.rate;
    unique case (state_r)
      S_IDLE: begin
        if (task_valid && res_space) begin
          task_pop = 1'b1;
          if (task_head.rate_zero) begin
            res_push = 1'b1;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          div_nxt   = div_rsp.quot;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (div_r == 32'd0) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end else if (div_r[31:16] == 16'd0) begin
          res_push                = 1'b1;
          res_data.status         = tdfs_pkg::STATUS_OK;
          res_data.reload_value   = div_r[15:0] - 16'd1;
          state_nxt               = S_IDLE;
        end else begin
          r_nxt     = r0_clamp;
          have_nxt  = 1'b0;
          state_nxt = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (sat) begin
          q_nxt     = tdfs_pkg::FACTOR_MAX;
          err_nxt   = div_r - {r_r, 16'd0} + {16'd0, r_r};
          state_nxt = S_EVAL;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = STEPS_HALF;
          div_req.rem_init = {16'd0, div_r[31:16]};
          div_req.dividend = {div_r[15:0], 16'd0};
          div_req.divisor  = {16'd0, r_r};
          state_nxt        = S_TWAIT;
        end
      end
      S_TWAIT: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quot[15:0];
          err_nxt   = div_rsp.rem;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!have_r || err_r < best_err_r) begin
          have_nxt     = 1'b1;
          best_err_nxt = err_r;
          best_r_nxt   = r_r;
          best_q_nxt   = q_r;
        end
        if (err_r == 32'd0 || r_r == tdfs_pkg::FACTOR_MAX) begin
          state_nxt = S_FINISH;
        end else begin
          r_nxt     = r_r + 16'd1;
          state_nxt = S_TRIAL;
        end
      end
      S_FINISH: begin
        res_push        = 1'b1;
        res_data.status = tdfs_pkg::STATUS_OK;
        if (best_r > best_q_r) begin
          res_data.prescale_value = best_q_r - 16'd1;
          res_data.reload_value   = best_r - 16'd1;
        end else begin
          res_data.prescale_value = best_r - 16'd1;
          res_data.reload_value   = best_q_r - 16'd1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    err_r      <= err_nxt;
    best_r     <= best_r_nxt;
    best_q_r   <= best_q_nxt;
    best_err_r <= best_err_nxt;
  end

  // result queue
  assign empty    = (res_cnt_r == 2'd0);
  assign res_pop  = pop && !empty;
  assign out_item = res_mem[res_rd_r];

  always_comb begin
    res_wr_nxt  = res_push ? ~res_wr_r : res_wr_r;
    res_rd_nxt  = res_pop ? ~res_rd_r : res_rd_r;
    res_cnt_nxt = res_cnt_r + {1'b0, res_push} - {1'b0, res_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      res_wr_r  <= res_wr_nxt;
      res_rd_r  <= res_rd_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr_r] <= res_data;
    end
  end

  // divider answers only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV || state_r == S_TWAIT))
    else $error("back: divider finished outside a wait state");

  // a trial remainder never exceeds the divider
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> err_r <= div_r)
    else $error("back: trial remainder above divider");

  // a result is never pushed into a full queue unless one is popped with it
  a_res_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_space || res_pop))
    else $error("back: result pushed into full queue");

  // a lone push grows the result queue by one
  a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_pop) |=> res_cnt_r == $past(res_cnt_r) + 2'd1)
    else $error("back: result count did not follow push");

endmodule
